// File: rtl/pnt_pkg.sv
// ----------------------------------------------------------------------------
// pnt_pkg
// Shared types, register codes and constants of the photocell night timer.
// ----------------------------------------------------------------------------
package pnt_pkg;

  localparam int unsigned LEVEL_W = 10;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned HOUR_W  = 4;
  localparam int unsigned MODE_W  = 2;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_MARGIN   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_TICKS  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_HOUR = 8'd3;

  localparam logic [LEVEL_W-1:0] DARK_THRESHOLD_RST = 10'd600;
  localparam logic [LEVEL_W-1:0] LIGHT_MARGIN_RST   = 10'd90;
  localparam logic [CNT_W-1:0]   CONFIRM_TICKS_RST  = 8'd40;
  localparam logic [TICK_W-1:0]  TICKS_PER_HOUR_RST = 16'd35700;

  // mode codes as seen on the result word
  localparam logic [MODE_W-1:0] MODE_WAIT    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ON      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EXPIRED = 2'd2;

  // trimpot breakpoints and the on-times they select
  localparam logic [LEVEL_W-1:0] TRIM_LIM_1H  = 10'd58;
  localparam logic [LEVEL_W-1:0] TRIM_LIM_2H  = 10'd365;
  localparam logic [LEVEL_W-1:0] TRIM_LIM_3H  = 10'd560;
  localparam logic [LEVEL_W-1:0] TRIM_LIM_4H  = 10'd670;
  localparam logic [LEVEL_W-1:0] TRIM_LIM_6H  = 10'd755;
  localparam logic [LEVEL_W-1:0] TRIM_LIM_8H  = 10'd828;
  localparam logic [LEVEL_W-1:0] TRIM_LIM_10H = 10'd950;

  typedef enum logic [2:0] {
    ST_WAIT    = 3'b001,
    ST_ON      = 3'b010,
    ST_EXPIRED = 3'b100
  } run_state_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] dark_threshold;
    logic [LEVEL_W-1:0] light_margin;
    logic [CNT_W-1:0]   confirm_ticks;
    logic [TICK_W-1:0]  ticks_per_hour;
  } cfg_t;

  typedef struct packed {
    run_state_e         run_state;
    logic [CNT_W-1:0]   dark_cnt;
    logic [CNT_W-1:0]   light_cnt;
    logic [TICK_W-1:0]  tick_cnt;
    logic [HOUR_W-1:0]  hour_cnt;
    logic [HOUR_W-1:0]  hours_lat;
  } timer_state_t;

  function automatic logic [HOUR_W-1:0] hours_from_trim(input logic [LEVEL_W-1:0] trim);
    logic [HOUR_W-1:0] h;
    priority if (trim < TRIM_LIM_1H)  h = 4'd1;
    else if (trim < TRIM_LIM_2H)      h = 4'd2;
    else if (trim < TRIM_LIM_3H)      h = 4'd3;
    else if (trim < TRIM_LIM_4H)      h = 4'd4;
    else if (trim < TRIM_LIM_6H)      h = 4'd6;
    else if (trim < TRIM_LIM_8H)      h = 4'd8;
    else if (trim < TRIM_LIM_10H)     h = 4'd10;
    else                              h = 4'd12;
    return h;
  endfunction

  function automatic logic [MODE_W-1:0] mode_code(input run_state_e s);
    logic [MODE_W-1:0] m;
    unique case (s)
      ST_ON:      m = MODE_ON;
      ST_EXPIRED: m = MODE_EXPIRED;
      default:    m = MODE_WAIT;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/pnt_if.sv
// ----------------------------------------------------------------------------
// pnt_if
// Valid/ready channels of the photocell night timer: tick input, result
// output and configuration write.
// ----------------------------------------------------------------------------
interface pnt_in_if;
  logic                        valid;
  logic                        ready;
  logic [pnt_pkg::LEVEL_W-1:0] light_level;
  logic [pnt_pkg::LEVEL_W-1:0] trim_level;

  modport source (output valid, light_level, trim_level, input ready);
  modport sink   (input valid, light_level, trim_level, output ready);
endinterface

interface pnt_out_if;
  logic                        valid;
  logic                        ready;
  logic                        relay_on;
  logic [pnt_pkg::MODE_W-1:0]  mode;
  logic [pnt_pkg::HOUR_W-1:0]  hours_chosen;

  modport source (output valid, relay_on, mode, hours_chosen, input ready);
  modport sink   (input valid, relay_on, mode, hours_chosen, output ready);
endinterface

interface pnt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pnt_pkg::CFG_IDX_W-1:0]  index;
  logic [pnt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/pnt_step.sv
// ----------------------------------------------------------------------------
// pnt_step
// Next-state logic of the timer for one tick: night/day confirmation,
// on-time latch and the tick/hour counters.
// ----------------------------------------------------------------------------
module pnt_step (
  input  pnt_pkg::cfg_t                   cfg_i,
  input  pnt_pkg::timer_state_t           state_i,
  input  logic [pnt_pkg::LEVEL_W-1:0]     light_level_i,
  input  logic [pnt_pkg::LEVEL_W-1:0]     trim_level_i,
  output pnt_pkg::timer_state_t           state_o
);

  logic [pnt_pkg::CNT_W-1:0]   confirm;
  logic [pnt_pkg::TICK_W-1:0]  tph;
  logic [pnt_pkg::LEVEL_W-1:0] light_limit;
  logic                        dark;
  logic                        light;
  logic [pnt_pkg::CNT_W-1:0]   dark_inc;
  logic [pnt_pkg::CNT_W-1:0]   light_inc;
  logic [pnt_pkg::TICK_W-1:0]  tick_inc;
  logic [pnt_pkg::HOUR_W-1:0]  hour_inc;

  always_comb begin
    confirm     = (cfg_i.confirm_ticks == '0) ? pnt_pkg::CNT_W'(1) : cfg_i.confirm_ticks;
    tph         = (cfg_i.ticks_per_hour == '0) ? pnt_pkg::TICK_W'(1) : cfg_i.ticks_per_hour;
    // margin above threshold floors the light limit at zero
    light_limit = (cfg_i.dark_threshold > cfg_i.light_margin) ?
                  (cfg_i.dark_threshold - cfg_i.light_margin) : '0;
    dark        = light_level_i > cfg_i.dark_threshold;
    light       = light_level_i < light_limit;

    dark_inc  = (state_i.dark_cnt == '1) ? state_i.dark_cnt : state_i.dark_cnt + 1'b1;
    light_inc = (state_i.light_cnt == '1) ? state_i.light_cnt : state_i.light_cnt + 1'b1;
    tick_inc  = state_i.tick_cnt + 1'b1;
    hour_inc  = state_i.hour_cnt + 1'b1;

    state_o = state_i;
    unique case (state_i.run_state)
      pnt_pkg::ST_ON: begin
        state_o.light_cnt = light ? light_inc : '0;
        if (state_o.light_cnt >= confirm) begin
          state_o.run_state = pnt_pkg::ST_WAIT;
          state_o.dark_cnt  = '0;
          state_o.light_cnt = '0;
        end else begin
          state_o.tick_cnt = tick_inc;
          if (tick_inc >= tph) begin
            state_o.tick_cnt = '0;
            state_o.hour_cnt = hour_inc;
            if (hour_inc >= state_i.hours_lat) begin
              state_o.run_state = pnt_pkg::ST_EXPIRED;
              state_o.light_cnt = '0;
            end
          end
        end
      end
      pnt_pkg::ST_EXPIRED: begin
        // stay off until the reading is no longer dark
        if (!dark) begin
          state_o.run_state = pnt_pkg::ST_WAIT;
          state_o.dark_cnt  = '0;
        end
      end
      default: begin
        state_o.run_state = pnt_pkg::ST_WAIT;
        state_o.dark_cnt  = dark ? dark_inc : '0;
        if (state_o.dark_cnt >= confirm) begin
          state_o.run_state = pnt_pkg::ST_ON;
          state_o.hours_lat = pnt_pkg::hours_from_trim(trim_level_i);
          state_o.dark_cnt  = '0;
          state_o.light_cnt = '0;
          state_o.tick_cnt  = '0;
          state_o.hour_cnt  = '0;
        end
      end
    endcase
  end

endmodule

// File: rtl/photocell_night_timer.sv
// ----------------------------------------------------------------------------
// photocell_night_timer
// Dusk-to-timeout relay controller with light hysteresis, one tick per word.
// ----------------------------------------------------------------------------
// Each input word is one sensor tick and yields exactly one result word that
// shows the relay, mode and latched on-time after that tick. A word passes an
// input register and then the result register, where its result is held until
// it is taken. A new tick is accepted every cycle while the result register is
// not stalled: the state update is a loop through the step logic and the
// state register, and the result register is refilled in the cycle it is taken.
// Configuration is written on its own channel, which is always ready; writes
// to unknown indexes are ignored. After reset no initialization pass is needed.
module photocell_night_timer (
  input  logic      clk_i,
  input  logic      rst_ni,
  pnt_in_if.sink    in_i,
  pnt_out_if.source out_o,
  pnt_cfg_if.sink   cfg_i
);

  pnt_pkg::cfg_t         cfg_q;
  pnt_pkg::timer_state_t state_q, state_d;

  logic                        in_valid_q;
  logic [pnt_pkg::LEVEL_W-1:0] light_q;
  logic [pnt_pkg::LEVEL_W-1:0] trim_q;
  logic                        out_valid_q;
  logic                        relay_q;
  logic [pnt_pkg::MODE_W-1:0]  mode_q;
  logic [pnt_pkg::HOUR_W-1:0]  hours_q;
  logic                        advance;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dark_threshold <= pnt_pkg::DARK_THRESHOLD_RST;
      cfg_q.light_margin   <= pnt_pkg::LIGHT_MARGIN_RST;
      cfg_q.confirm_ticks  <= pnt_pkg::CONFIRM_TICKS_RST;
      cfg_q.ticks_per_hour <= pnt_pkg::TICKS_PER_HOUR_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        pnt_pkg::CFG_DARK_THRESHOLD: cfg_q.dark_threshold <= cfg_i.data[pnt_pkg::LEVEL_W-1:0];
        pnt_pkg::CFG_LIGHT_MARGIN:   cfg_q.light_margin   <= cfg_i.data[pnt_pkg::LEVEL_W-1:0];
        pnt_pkg::CFG_CONFIRM_TICKS:  cfg_q.confirm_ticks  <= cfg_i.data[pnt_pkg::CNT_W-1:0];
        pnt_pkg::CFG_TICKS_PER_HOUR: cfg_q.ticks_per_hour <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      light_q <= in_i.light_level;
      trim_q  <= in_i.trim_level;
    end
  end

  pnt_step u_step (
    .cfg_i         (cfg_q),
    .state_i       (state_q),
    .light_level_i (light_q),
    .trim_level_i  (trim_q),
    .state_o       (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.run_state <= pnt_pkg::ST_WAIT;
      state_q.dark_cnt  <= '0;
      state_q.light_cnt <= '0;
      state_q.tick_cnt  <= '0;
      state_q.hour_cnt  <= '0;
      state_q.hours_lat <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      relay_q <= (state_d.run_state == pnt_pkg::ST_ON);
      mode_q  <= pnt_pkg::mode_code(state_d.run_state);
      hours_q <= state_d.hours_lat;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.relay_on     = relay_q;
  assign out_o.mode         = mode_q;
  assign out_o.hours_chosen = hours_q;

endmodule

// File: rtl/pnt_checker.sv
// ----------------------------------------------------------------------------
// pnt_checker
// Port-level checks of the photocell night timer, bound to the top level.
// ----------------------------------------------------------------------------
module pnt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        relay_on_i,
  input logic [pnt_pkg::MODE_W-1:0]  mode_i,
  input logic [pnt_pkg::HOUR_W-1:0]  hours_chosen_i
);

  // relay follows the mode word
  a_relay_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (relay_on_i == (mode_i == pnt_pkg::MODE_ON)))
    else $error("relay_on disagrees with mode");

  // unused mode code never shows
  a_mode_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (mode_i == pnt_pkg::MODE_WAIT || mode_i == pnt_pkg::MODE_ON ||
                     mode_i == pnt_pkg::MODE_EXPIRED))
    else $error("unused mode code on output");

  // while timing, the latched on-time is one of the trimpot steps
  a_hours_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && mode_i == pnt_pkg::MODE_ON) |->
      (hours_chosen_i == 4'd1 || hours_chosen_i == 4'd2 || hours_chosen_i == 4'd3 ||
       hours_chosen_i == 4'd4 || hours_chosen_i == 4'd6 || hours_chosen_i == 4'd8 ||
       hours_chosen_i == 4'd10 || hours_chosen_i == 4'd12))
    else $error("invalid on-time while relay on");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(relay_on_i) && $stable(mode_i) && $stable(hours_chosen_i)))
    else $error("result word changed while stalled");

endmodule

bind photocell_night_timer pnt_checker u_pnt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .relay_on_i     (out_o.relay_on),
  .mode_i         (out_o.mode),
  .hours_chosen_i (out_o.hours_chosen)
);
